@@ hdl/swbrm_pkg.sv @@
`default_nettype none

package swbrm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);

  localparam int WIN_W   = 7;
  localparam int SEC_W   = 32;
  localparam int PKT_W   = 16;
  localparam int BYTES_W = 48;
  localparam int RATE_W  = 56;
  localparam int CNT_W   = 7;
  localparam int FRAC_W  = 8;

  // divider retires this many quotient bits per cycle
  localparam int DIV_STEP  = 8;
  localparam int DIV_ITER  = RATE_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd60;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);

  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic div_rate;
    logic restart;
    logic walk_init;
    logic rd_req;
    logic rd_newest;
    logic walk_wr;
    logic same_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_query;
    logic has_data;
    logic gap_ge_w;
    logic gap_zero;
    logic walk_last;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/swbrm_in_if.sv @@
`default_nettype none

interface swbrm_in_if import swbrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SEC_W-1:0] now_sec;
  logic [PKT_W-1:0] packet_bytes;

  modport source (output valid, output opcode, output now_sec, output packet_bytes,
                  input ready);
  modport sink   (input valid, input opcode, input now_sec, input packet_bytes,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/swbrm_out_if.sv @@
`default_nettype none

interface swbrm_out_if import swbrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTES_W-1:0] total_bytes;
  logic [RATE_W-1:0]  rate_q8;
  logic [CNT_W-1:0]   filled_slots;

  modport source (output valid, output total_bytes, output rate_q8, output filled_slots,
                  input ready);
  modport sink   (input valid, input total_bytes, input rate_q8, input filled_slots,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/swbrm_div.sv @@
`default_nettype none

module swbrm_div import swbrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RATE_W-1:0] dividend,
  input  logic [WIN_W-1:0]  divisor,
  output logic              busy,
  output logic [RATE_W-1:0] quotient,
  output logic [WIN_W-1:0]  remainder
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [RATE_W-1:0]    quo_r;
  logic [RATE_W-1:0]    quo_nxt;
  logic [WIN_W-1:0]     rem_r;
  logic [WIN_W-1:0]     rem_nxt;

  // restoring division, dividend shifts out of the top as quotient shifts in
  always_comb begin
    logic [RATE_W-1:0] q;
    logic [WIN_W-1:0]  r;
    logic [WIN_W:0]    t;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, q[RATE_W-1]};
      q = {q[RATE_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[WIN_W-1:0];
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ hdl/swbrm_ctrl.sv @@
`default_nettype none

module swbrm_ctrl import swbrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cfg_clear,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_SAME   = 3'd3;
  localparam logic [2:0] S_WRD    = 3'd4;
  localparam logic [2:0] S_WWR    = 3'd5;
  localparam logic [2:0] S_RSTART = 3'd6;
  localparam logic [2:0] S_RATE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.clear = cfg_clear;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op_query) begin
          if (stat.gap_ge_w) begin
            cmd.clear = 1'b1;
          end
          state_nxt = S_RSTART;
        end else if (!stat.has_data || stat.gap_ge_w) begin
          // restart slot is now mod window, taken from the divider
          cmd.div_start = 1'b1;
          state_nxt     = S_MOD;
        end else if (stat.gap_zero) begin
          cmd.rd_req    = 1'b1;
          cmd.rd_newest = 1'b1;
          state_nxt     = S_SAME;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WRD;
        end
      end
      S_MOD: begin
        if (!stat.div_busy) begin
          cmd.restart = 1'b1;
          state_nxt   = S_RSTART;
        end
      end
      S_SAME: begin
        cmd.same_wr = 1'b1;
        state_nxt   = S_RSTART;
      end
      S_WRD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_WWR;
      end
      S_WWR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = stat.walk_last ? S_RSTART : S_WRD;
      end
      S_RSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_rate  = 1'b1;
        state_nxt     = S_RATE;
      end
      S_RATE: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/swbrm_dp.sv @@
`default_nettype none

module swbrm_dp import swbrm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [WIN_W-1:0]   win,
  input  logic               in_opcode,
  input  logic [SEC_W-1:0]   in_now_sec,
  input  logic [PKT_W-1:0]   in_packet_bytes,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BYTES_W-1:0] out_total_bytes,
  output logic [RATE_W-1:0]  out_rate_q8,
  output logic [CNT_W-1:0]   out_filled_slots
);

  localparam int ENTRY_W = SEC_W + BYTES_W;

  // current item
  logic               op_r;
  logic [SEC_W-1:0]   now_r;
  logic [SEC_W-1:0]   gap_r;
  logic [PKT_W-1:0]   pkt_r;

  // window state
  logic [SLOT_W-1:0]  newest_slot_r;
  logic               has_data_r;
  logic [SEC_W-1:0]   newest_second_r;
  logic [BYTES_W-1:0] total_r;
  logic [CNT_W-1:0]   count_r;

  // walk over skipped slots
  logic [SLOT_W-1:0]  step_r;
  logic [SEC_W-1:0]   stamp_r;

  // slot store {second, bytes}
  logic [ENTRY_W-1:0]    slot_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] valid_r;
  logic [SLOT_W-1:0]     rd_addr_r;
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  rd_valid_r;

  logic               out_valid_r;
  logic [BYTES_W-1:0] out_total_r;
  logic [RATE_W-1:0]  out_rate_r;
  logic [CNT_W-1:0]   out_count_r;

  logic [SLOT_W:0]    slot_inc;
  logic [SLOT_W-1:0]  next_slot;
  logic [SLOT_W-1:0]  rd_addr;
  logic [BYTES_W-1:0] old_bytes;
  logic [SEC_W-1:0]   old_sec;
  logic [SEC_W-1:0]   age;
  logic               walk_last;
  logic [BYTES_W-1:0] add_bytes;
  logic [BYTES_W-1:0] walk_bytes;
  logic [BYTES_W-1:0] walk_total;
  logic               dec;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   cnt_walk;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  logic               div_busy;
  logic [RATE_W-1:0]  div_quo;
  logic [WIN_W-1:0]   div_rem;
  logic [RATE_W-1:0]  div_dividend;

  assign slot_inc  = {1'b0, newest_slot_r} + (SLOT_W+1)'(1);
  assign next_slot = (WIN_W'(slot_inc) == win) ? '0 : slot_inc[SLOT_W-1:0];
  assign rd_addr   = cmd.rd_newest ? newest_slot_r : next_slot;

  // a slot not written since the last clear or restart reads as zero
  assign old_bytes = rd_valid_r ? rd_data_r[BYTES_W-1:0] : '0;
  assign old_sec   = rd_valid_r ? rd_data_r[BYTES_W +: SEC_W] : '0;
  assign age       = newest_second_r - old_sec;

  assign walk_last  = (step_r == SLOT_W'(1));
  assign add_bytes  = BYTES_W'(pkt_r);
  assign walk_bytes = walk_last ? add_bytes : '0;
  assign walk_total = total_r - old_bytes + walk_bytes;

  assign dec      = (old_sec != '0) && (age < SEC_W'(win)) && (count_r != '0);
  assign cnt_dec  = count_r - CNT_W'(dec);
  assign cnt_walk = (cnt_dec < win) ? cnt_dec + CNT_W'(1) : cnt_dec;

  assign mem_we = cmd.restart | cmd.walk_wr | cmd.same_wr;

  always_comb begin
    if (cmd.restart) begin
      mem_wa = div_rem[SLOT_W-1:0];
      mem_wd = {now_r, add_bytes};
    end else if (cmd.walk_wr) begin
      mem_wa = rd_addr_r;
      mem_wd = {stamp_r, walk_bytes};
    end else begin
      mem_wa = newest_slot_r;
      mem_wd = {old_sec, old_bytes + add_bytes};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_req) begin
      rd_data_r  <= slot_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
      rd_addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.restart) begin
      // only the restart slot stays live
      valid_r <= WINDOW_MAX'(1) << mem_wa;
    end else if (cmd.walk_wr) begin
      valid_r[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      newest_slot_r   <= '0;
      has_data_r      <= 1'b0;
      newest_second_r <= '0;
      total_r         <= '0;
      count_r         <= '0;
    end else if (cmd.restart) begin
      newest_slot_r   <= mem_wa;
      has_data_r      <= 1'b1;
      newest_second_r <= now_r;
      total_r         <= add_bytes;
      count_r         <= CNT_W'(1);
    end else if (cmd.walk_wr) begin
      newest_slot_r <= rd_addr_r;
      total_r       <= walk_total;
      count_r       <= cnt_walk;
      if (walk_last) begin
        newest_second_r <= now_r;
      end
    end else if (cmd.same_wr) begin
      total_r <= total_r + add_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      now_r <= in_now_sec;
      pkt_r <= in_packet_bytes;
      gap_r <= in_now_sec - newest_second_r;
    end
    if (cmd.walk_init) begin
      // gap is below the window here, so it fits the slot index width
      step_r  <= gap_r[SLOT_W-1:0];
      stamp_r <= newest_second_r + SEC_W'(1);
    end else if (cmd.walk_wr) begin
      step_r  <= step_r - SLOT_W'(1);
      stamp_r <= stamp_r + SEC_W'(1);
    end
  end

  assign div_dividend = cmd.div_rate ? {total_r, FRAC_W'(0)} : RATE_W'(now_r);

  swbrm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (win),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total_r <= total_r;
      out_rate_r  <= div_quo;
      out_count_r <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_total_bytes  = out_total_r;
  assign out_rate_q8      = out_rate_r;
  assign out_filled_slots = out_count_r;

  assign stat.op_query  = (op_r == OP_QUERY);
  assign stat.has_data  = has_data_r;
  assign stat.gap_ge_w  = (gap_r >= SEC_W'(win));
  assign stat.gap_zero  = (gap_r == '0);
  assign stat.walk_last = walk_last;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

@@ hdl/sliding_window_byte_rate_meter.sv @@
// Byte rate meter over a sliding window of one-second slots.
// in_chan (valid/ready): opcode 0 adds packet_bytes at now_sec, opcode 1
// queries, and empties the window if now_sec is a window or more past the
// newest second. Each item gives exactly one result on out_chan: the running
// byte total, total*256/window truncated, and the number of filled slots.
// cfg port (APB style, pready always high): register 0 at byte address 0 is
// window_seconds; 0 acts as 1, values above 64 act as 64. A write also empties
// the window. Write it only while no item is in flight.
// The block is ready for the next item in the cycle after the result is
// loaded. The rate is set by the shared 8-bit-per-cycle divider (once for the
// rate, and once more for now mod window on a restart) and by one slot read
// plus one slot write per skipped second in the slot memory.
// The result sits in an output register; when the receiver stalls, the block
// finishes the next item and then holds it until that register frees up.
// Reset (synchronous, rst_n low) empties the window and sets the window to 60.
`default_nettype none

module sliding_window_byte_rate_meter import swbrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  swbrm_in_if.sink          in_chan,
  swbrm_out_if.source       out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [WIN_W-1:0] window_r;
  logic [WIN_W-1:0] win_eff;
  logic             cfg_wr;
  logic             win_wr;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             in_ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign win_wr     = cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_WINDOW);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_WINDOW) ? CFG_DW'(window_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (win_wr) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    if (window_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(WINDOW_MAX)) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end else begin
      win_eff = window_r;
    end
  end

  assign in_chan.ready = in_ready;

  swbrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .cfg_clear (win_wr),
    .cmd       (cmd),
    .stat      (stat)
  );

  swbrm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .win              (win_eff),
    .in_opcode        (in_chan.opcode),
    .in_now_sec       (in_chan.now_sec),
    .in_packet_bytes  (in_chan.packet_bytes),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_total_bytes  (out_chan.total_bytes),
    .out_rate_q8      (out_chan.rate_q8),
    .out_filled_slots (out_chan.filled_slots)
  );

endmodule

`default_nettype wire

@@ test/sliding_window_byte_rate_meter_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_byte_rate_meter_tb;
  import swbrm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 140;
  localparam int NUM_PHASES     = 9;

  localparam logic [CFG_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE  = CFG_AW'(4);

  typedef struct {
    logic [BYTES_W-1:0] total;
    logic [RATE_W-1:0]  rate;
    logic [CNT_W-1:0]   filled;
  } meter_result_t;

  class rate_meter_scoreboard;
    logic [BYTES_W-1:0] slot_bytes [WINDOW_MAX];
    logic [SEC_W-1:0]   slot_sec [WINDOW_MAX];
    int unsigned        newest_slot;
    bit                 has_data;
    logic [SEC_W-1:0]   newest_sec;
    logic [BYTES_W-1:0] byte_total;
    int unsigned        active;
    logic [WIN_W-1:0]   window_reg;
    meter_result_t      expected_results[$];
    int                 errors;

    function new();
      window_reg = WINDOW_RESET;
      errors = 0;
      empty_window();
    endfunction

    function void empty_window();
      foreach (slot_bytes[i]) begin
        slot_bytes[i] = '0;
        slot_sec[i] = '0;
      end
      newest_slot = 0;
      has_data = 1'b0;
      newest_sec = '0;
      byte_total = '0;
      active = 0;
    endfunction

    function int unsigned window_len();
      if (window_reg == 0) return 1;
      if (window_reg > WINDOW_MAX) return WINDOW_MAX;
      return window_reg;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      if (addr != ADDR_WINDOW) return;
      window_reg = data[WIN_W-1:0];
      empty_window();
    endfunction

    function void note_item(logic op, logic [SEC_W-1:0] now, logic [PKT_W-1:0] pkt);
      int unsigned      w;
      int unsigned      idx;
      logic [SEC_W-1:0] gap;
      meter_result_t    res;
      w = window_len();
      gap = now - newest_sec;
      if (op == OP_ADD) begin
        if (!has_data || gap >= w) begin
          empty_window();
          idx = now % w;
          slot_bytes[idx] = BYTES_W'(pkt);
          slot_sec[idx] = now;
          byte_total = BYTES_W'(pkt);
          newest_slot = idx;
          newest_sec = now;
          active = 1;
          has_data = 1'b1;
        end else if (gap == 0) begin
          idx = newest_slot % w;
          slot_bytes[idx] = slot_bytes[idx] + BYTES_W'(pkt);
          byte_total = byte_total + BYTES_W'(pkt);
        end else begin
          // retire each skipped second in turn
          for (int unsigned k = 1; k <= gap; k++) begin
            idx = (newest_slot + 1) % w;
            byte_total = byte_total - slot_bytes[idx];
            if (slot_sec[idx] != 0 && SEC_W'(newest_sec - slot_sec[idx]) < w && active > 0)
              active--;
            slot_bytes[idx] = '0;
            slot_sec[idx] = newest_sec + SEC_W'(k);
            if (active < w) active++;
            newest_slot = idx;
          end
          slot_bytes[newest_slot] = slot_bytes[newest_slot] + BYTES_W'(pkt);
          byte_total = byte_total + BYTES_W'(pkt);
          newest_sec = now;
        end
      end else if (gap >= w) begin
        empty_window();
      end
      res.total = byte_total;
      res.rate = {byte_total, FRAC_W'(0)} / RATE_W'(w);
      res.filled = CNT_W'(active);
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [BYTES_W-1:0] total, logic [RATE_W-1:0] rate,
                               logic [CNT_W-1:0] filled);
      meter_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no item waiting: total_bytes %0d", total);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (total !== want.total) begin
        $error("total_bytes: expected %0d, got %0d", want.total, total);
        errors++;
      end
      if (rate !== want.rate) begin
        $error("rate_q8: expected %0d, got %0d", want.rate, rate);
        errors++;
      end
      if (filled !== want.filled) begin
        $error("filled_slots: expected %0d, got %0d", want.filled, filled);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  swbrm_in_if  in_if ();
  swbrm_out_if out_if ();

  rate_meter_scoreboard sb = new();

  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  int stall_cycles = 0;

  sliding_window_byte_rate_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_item(in_if.opcode, in_if.now_sec, in_if.packet_bytes);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.total_bytes, out_if.rate_q8, out_if.filled_slots);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result receiver
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        // long hold so the block fills up and backs up its input
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(logic op, logic [SEC_W-1:0] now, logic [PKT_W-1:0] pkt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.now_sec <= now;
    in_if.packet_bytes <= pkt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_register(addr, data);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic cfg_check_window();
    logic [CFG_DW-1:0] want;
    want = CFG_DW'(sb.window_reg);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_WINDOW;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      $error("window_seconds: expected %0d, got %0d", want, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_random(int count);
    logic [SEC_W-1:0] cursor;
    logic [PKT_W-1:0] pkt;
    logic             op;
    int unsigned      w;
    int               r;
    w = sb.window_len();
    case ($urandom_range(0, 2))
      0: cursor = SEC_W'($urandom_range(0, 20));
      1: cursor = 32'hFFFF_FFFF - SEC_W'($urandom_range(0, 80));
      default: cursor = $urandom();
    endcase
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // same second
      end else if (r < 80) begin
        cursor = cursor + SEC_W'($urandom_range(1, 3));
      end else if (r < 86) begin
        if (w > 1) cursor = cursor + SEC_W'($urandom_range(1, w - 1));
      end else if (r < 91) begin
        cursor = cursor + SEC_W'(w + $urandom_range(0, 5));
      end else if (r < 95) begin
        cursor = cursor - SEC_W'($urandom_range(1, 100));
      end else begin
        cursor = $urandom();
      end
      op = ($urandom_range(0, 99) < 80) ? OP_ADD : OP_QUERY;
      r = $urandom_range(0, 99);
      if (r < 10) pkt = 16'hFFFF;
      else if (r < 15) pkt = '0;
      else pkt = PKT_W'($urandom());
      send_item(op, cursor, pkt);
    end
  endtask

  initial begin
    logic [CFG_DW-1:0] wdata;
    logic [WIN_W-1:0]  win;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_ADD;
    in_if.now_sec = '0;
    in_if.packet_bytes = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_check_window();

    // directed items at the reset window of 60 seconds
    send_item(OP_QUERY, 32'd0, 16'hFFFF);          // query on an empty window
    send_item(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);    // first add restarts
    send_item(OP_ADD, 32'hFFFF_FFFF, 16'h0000);
    send_item(OP_ADD, 32'd0, 16'h0001);            // time wraps, slot stamped zero
    send_item(OP_ADD, 32'd2, 16'h8000);
    send_item(OP_QUERY, 32'd40, 16'h1234);
    send_item(OP_ADD, 32'd61, 16'h7FFF);           // gap of window minus one
    send_item(OP_ADD, 32'd121, 16'hAAAA);          // gap of exactly the window
    send_item(OP_ADD, 32'd100, 16'h5555);          // time going backward
    send_item(OP_QUERY, 32'd99, 16'h0000);
    send_item(OP_QUERY, 32'd99, 16'h0F0F);
    send_item(OP_ADD, 32'd0, 16'h00FF);
    send_item(OP_ADD, 32'd1, 16'hFF00);
    send_item(OP_ADD, 32'd1, 16'hFFFF);
    send_item(OP_QUERY, 32'd1, 16'hFFFF);
    send_item(OP_ADD, 32'd65, 16'h0101);
    send_item(OP_QUERY, 32'd124, 16'h0000);
    send_item(OP_QUERY, 32'd125, 16'h0000);
    send_item(OP_ADD, 32'd126, 16'hFFFE);
    send_item(OP_ADD, 32'd130, 16'h0002);
    finish_phase();

    for (int p = 0; p < NUM_PHASES; p++) begin
      no_idle = (p % 3 == 2);
      if (p == 0) begin
        // a write to the unused address leaves the window alone
        send_item(OP_ADD, 32'd500, 16'h1111);
        finish_phase();
        cfg_write(ADDR_SPARE, $urandom());
      end else begin
        case (p)
          1: win = 7'd64;
          2: win = 7'd1;
          3: win = 7'd0;
          4: win = 7'd127;
          5: win = 7'd65;
          6: win = 7'd2;
          7: win = 7'd13;
          default: win = WIN_W'($urandom_range(1, WINDOW_MAX));
        endcase
        wdata = $urandom();
        wdata[WIN_W-1:0] = win;
        cfg_write(ADDR_WINDOW, wdata);
      end
      cfg_check_window();
      if (p == 1) hold_request = 1'b1;
      run_random(PHASE_ITEMS);
      finish_phase();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
hdl/swbrm_pkg.sv
hdl/swbrm_in_if.sv
hdl/swbrm_out_if.sv
hdl/swbrm_div.sv
hdl/swbrm_ctrl.sv
hdl/swbrm_dp.sv
hdl/sliding_window_byte_rate_meter.sv
test/sliding_window_byte_rate_meter_tb.sv
